@@ rtl/scanline_gradient_generator_assert.svh @@
// Assertion helpers for the top RTL file of the scanline gradient generator.
`ifndef SCANLINE_GRADIENT_GENERATOR_ASSERT_SVH
`define SCANLINE_GRADIENT_GENERATOR_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SGG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SGG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sgg_pkg.sv @@
package sgg_pkg;

	// Field widths.
	localparam int LINE_W    = 10;
	localparam int CHAN_W    = 8;
	localparam int COLOR_W   = 15;
	localparam int KF_W      = 34;
	localparam int CFG_IDX_W = 3;
	localparam int SLOT_W    = 3;

	// Keyframe table size.
	localparam int NUM_KEYFRAMES_DEF = 7;

	// Keyframe packing.
	localparam int KF_LINE_LSB  = 24;
	localparam int KF_RED_LSB   = 16;
	localparam int KF_GREEN_LSB = 8;
	localparam int KF_BLUE_LSB  = 0;

	// Start line that marks the hold-to-end keyframe.
	localparam logic [LINE_W-1:0] HOLD_LINE = 10'd999;
	localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;

	// Serial arithmetic: product of an 8-bit delta and a 10-bit offset.
	localparam int PROD_W    = 18;
	localparam int MUL_STEPS = LINE_W;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = 5;

	// Per-cycle commands from the sequencer to the arithmetic lanes.
	typedef struct packed {
		logic load;
		logic mul;
		logic div;
	} sgg_ctrl_t;

	// Keyframe contents after reset.
	function automatic logic [KF_W-1:0] kf_reset_value(input logic [SLOT_W-1:0] idx);
		logic [KF_W-1:0] v;
		case (idx)
			3'd0: v = 34'd5860232;
			3'd1: v = 34'd676948872;
			3'd2: v = 34'd1353200660;
			3'd3: v = 34'd1856808240;
			3'd4: v = 34'd2024580400;
			3'd5: v = 34'd2359833620;
			3'd6: v = 34'd16771462164;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/sgg_line_if.sv @@
interface sgg_line_if;
	logic                       valid;
	logic                       ready;
	logic [sgg_pkg::LINE_W-1:0] line_number;
	logic                       frame_start;

	modport source (output valid, line_number, frame_start, input ready);
	modport sink (input valid, line_number, frame_start, output ready);
endinterface

@@ rtl/sgg_color_if.sv @@
interface sgg_color_if;
	logic                        valid;
	logic                        ready;
	logic [sgg_pkg::LINE_W-1:0]  line_address;
	logic [sgg_pkg::COLOR_W-1:0] color_word;

	modport source (output valid, line_address, color_word, input ready);
	modport sink (input valid, line_address, color_word, output ready);
endinterface

@@ rtl/scanline_gradient_generator.sv @@
// Scanline gradient generator: one 15-bit background color per scanline.
// The lines channel carries a line number and a frame_start flag; each word
// yields exactly one word on the colors channel with the line number echoed
// as line_address and the packed color (blue, green, red, 5 bits each).
// Keyframes are written through cfg_we / cfg_index / cfg_data; the user must
// do so only while idle, as the block itself does not enforce it; indexes at
// or above NUM_KEYFRAMES are dropped. Table lookups in S_SEG and S_LOAD are
// followed by a shift-add multiply, one bit of the line offset per cycle, and
// a restoring divide, one quotient bit per cycle; the three color channels
// run in parallel lanes. A new line is taken only once the previous result
// has been loaded into the output register.
// Reset clears the segment pointers and returns every keyframe to its
// default; no clearing pass is needed.
// The result sits in an output register, so the next line is accepted while
// a color word still waits; if the receiver is still stalled when the next
// result is done, the block holds that result and stops taking lines.
module scanline_gradient_generator #(
	parameter int NUM_KEYFRAMES = sgg_pkg::NUM_KEYFRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sgg_line_if.sink                      lines,
	sgg_color_if.source                   colors,
	input  logic                          cfg_we,
	input  logic [sgg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sgg_pkg::KF_W-1:0]      cfg_data
);

	`include "scanline_gradient_generator_assert.svh"

	localparam int SEG_W = $clog2(NUM_KEYFRAMES);
	localparam logic [SEG_W-1:0] LAST = SEG_W'(NUM_KEYFRAMES - 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SEG  = 6'b000010,
		S_LOAD = 6'b000100,
		S_MUL  = 6'b001000,
		S_DIV  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                       state_q;
	logic [sgg_pkg::CNT_W-1:0]    cnt_q;
	logic [SEG_W-1:0]             cur_seg_q;
	logic [SEG_W-1:0]             prev_seg_q;
	logic [sgg_pkg::LINE_W-1:0]   line_q;
	logic                         fs_q;
	logic                         hold_q;
	logic [3*sgg_pkg::CHAN_W-1:0] prev_color_q;
	logic [NUM_KEYFRAMES-1:0]     kf_valid_q;
	logic [SEG_W-1:0]             raddr_a_q;
	logic [SEG_W-1:0]             raddr_b_q;
	logic                         rvalid_a_q;
	logic                         rvalid_b_q;
	logic                         out_valid_q;
	logic [sgg_pkg::LINE_W-1:0]   out_line_q;
	logic [sgg_pkg::COLOR_W-1:0]  out_color_q;

	logic                         in_accept;
	logic                         cfg_hit;
	logic [SEG_W-1:0]             raddr_a;
	logic [SEG_W-1:0]             raddr_b;
	logic [sgg_pkg::KF_W-1:0]     rdata_a;
	logic [sgg_pkg::KF_W-1:0]     rdata_b;
	logic [sgg_pkg::KF_W-1:0]     kf_a;
	logic [sgg_pkg::KF_W-1:0]     kf_b;
	logic [SEG_W-1:0]             seg_base;
	logic [SEG_W-1:0]             prev_base;
	logic                         advance;
	logic [SEG_W-1:0]             next_cur;
	logic [SEG_W-1:0]             next_prev;
	logic [sgg_pkg::LINE_W-1:0]   start_line;
	logic [sgg_pkg::LINE_W-1:0]   end_line;
	logic [sgg_pkg::LINE_W:0]     t0;
	logic [sgg_pkg::LINE_W:0]     t1;
	logic [sgg_pkg::LINE_W:0]     t0_abs;
	logic [sgg_pkg::LINE_W:0]     t1_abs;
	logic                         offs_neg;
	sgg_pkg::sgg_ctrl_t           ctrl;
	logic [sgg_pkg::CHAN_W-1:0]   red_lerp;
	logic [sgg_pkg::CHAN_W-1:0]   green_lerp;
	logic [sgg_pkg::CHAN_W-1:0]   blue_lerp;
	logic [sgg_pkg::CHAN_W-1:0]   red_ch;
	logic [sgg_pkg::CHAN_W-1:0]   green_ch;
	logic [sgg_pkg::CHAN_W-1:0]   blue_ch;
	logic                         fin_load;

	assign in_accept = lines.valid && lines.ready;
	assign lines.ready = (state_q == S_IDLE);
	assign cfg_hit = cfg_we
		&& ({1'b0, cfg_index} < (sgg_pkg::CFG_IDX_W + 1)'(NUM_KEYFRAMES));

	// Keyframe table.
	sgg_ram #(
		.WIDTH (sgg_pkg::KF_W),
		.DEPTH (NUM_KEYFRAMES)
	) u_kf_ram (
		.clk     (clk),
		.we      (cfg_hit),
		.waddr   (cfg_index[SEG_W-1:0]),
		.wdata   (cfg_data),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// Entries never written read as their reset defaults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kf_valid_q <= '0;
			rvalid_a_q <= 1'b0;
			rvalid_b_q <= 1'b0;
			raddr_a_q  <= '0;
			raddr_b_q  <= '0;
		end else begin
			if (cfg_hit) begin
				kf_valid_q[cfg_index[SEG_W-1:0]] <= 1'b1;
			end
			rvalid_a_q <= kf_valid_q[raddr_a];
			rvalid_b_q <= kf_valid_q[raddr_b];
			raddr_a_q  <= raddr_a;
			raddr_b_q  <= raddr_b;
		end
	end

	assign kf_a = rvalid_a_q ? rdata_a : sgg_pkg::kf_reset_value(sgg_pkg::SLOT_W'(raddr_a_q));
	assign kf_b = rvalid_b_q ? rdata_b : sgg_pkg::kf_reset_value(sgg_pkg::SLOT_W'(raddr_b_q));

	// Segment advance, evaluated against the keyframe read at accept time.
	assign seg_base  = fs_q ? '0 : cur_seg_q;
	assign prev_base = fs_q ? '0 : prev_seg_q;
	assign advance   = (line_q >= kf_a[sgg_pkg::KF_LINE_LSB +: sgg_pkg::LINE_W]);
	assign next_cur  = (advance && seg_base != LAST) ? seg_base + 1'b1 : seg_base;
	assign next_prev = advance ? seg_base : prev_base;

	// Read addresses: current segment (segment zero on a frame start) while idle, both ends of the segment next.
	always_comb begin
		raddr_a = cur_seg_q;
		raddr_b = cur_seg_q;
		case (state_q)
			S_IDLE: begin
				raddr_a = lines.frame_start ? '0 : cur_seg_q;
			end
			S_SEG: begin
				raddr_a = next_prev;
				raddr_b = next_cur;
			end
			default: begin
				raddr_a = cur_seg_q;
				raddr_b = cur_seg_q;
			end
		endcase
	end

	// Signed line offsets within the segment.
	assign start_line = kf_a[sgg_pkg::KF_LINE_LSB +: sgg_pkg::LINE_W];
	assign end_line   = kf_b[sgg_pkg::KF_LINE_LSB +: sgg_pkg::LINE_W];
	assign t0         = {1'b0, line_q} - {1'b0, start_line};
	assign t1         = {1'b0, end_line} - {1'b0, start_line};
	assign t0_abs     = t0[sgg_pkg::LINE_W] ? (~t0 + 1'b1) : t0;
	assign t1_abs     = t1[sgg_pkg::LINE_W] ? (~t1 + 1'b1) : t1;
	assign offs_neg   = t0[sgg_pkg::LINE_W] ^ t1[sgg_pkg::LINE_W];

	assign ctrl.load = (state_q == S_LOAD);
	assign ctrl.mul  = (state_q == S_MUL);
	assign ctrl.div  = (state_q == S_DIV);

	// Three channel lanes share the offsets and the sequencing.
	sgg_lane u_lane_red (
		.clk      (clk),
		.ctrl     (ctrl),
		.chan_a   (kf_a[sgg_pkg::KF_RED_LSB +: sgg_pkg::CHAN_W]),
		.chan_b   (kf_b[sgg_pkg::KF_RED_LSB +: sgg_pkg::CHAN_W]),
		.t0_mag   (t0_abs[sgg_pkg::LINE_W-1:0]),
		.t1_mag   (t1_abs[sgg_pkg::LINE_W-1:0]),
		.offs_neg (offs_neg),
		.chan_out (red_lerp)
	);

	sgg_lane u_lane_green (
		.clk      (clk),
		.ctrl     (ctrl),
		.chan_a   (kf_a[sgg_pkg::KF_GREEN_LSB +: sgg_pkg::CHAN_W]),
		.chan_b   (kf_b[sgg_pkg::KF_GREEN_LSB +: sgg_pkg::CHAN_W]),
		.t0_mag   (t0_abs[sgg_pkg::LINE_W-1:0]),
		.t1_mag   (t1_abs[sgg_pkg::LINE_W-1:0]),
		.offs_neg (offs_neg),
		.chan_out (green_lerp)
	);

	sgg_lane u_lane_blue (
		.clk      (clk),
		.ctrl     (ctrl),
		.chan_a   (kf_a[sgg_pkg::KF_BLUE_LSB +: sgg_pkg::CHAN_W]),
		.chan_b   (kf_b[sgg_pkg::KF_BLUE_LSB +: sgg_pkg::CHAN_W]),
		.t0_mag   (t0_abs[sgg_pkg::LINE_W-1:0]),
		.t1_mag   (t1_abs[sgg_pkg::LINE_W-1:0]),
		.offs_neg (offs_neg),
		.chan_out (blue_lerp)
	);

	// Empty and hold segments keep the start keyframe's color.
	assign red_ch   = hold_q ? prev_color_q[sgg_pkg::KF_RED_LSB +: sgg_pkg::CHAN_W] : red_lerp;
	assign green_ch = hold_q ? prev_color_q[sgg_pkg::KF_GREEN_LSB +: sgg_pkg::CHAN_W]
		: green_lerp;
	assign blue_ch  = hold_q ? prev_color_q[sgg_pkg::KF_BLUE_LSB +: sgg_pkg::CHAN_W] : blue_lerp;

	assign fin_load = (state_q == S_FIN) && (!out_valid_q || colors.ready);

	// Sequencer and segment pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			cur_seg_q  <= '0;
			prev_seg_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_SEG;
					end
				end
				S_SEG: begin
					cur_seg_q  <= next_cur;
					prev_seg_q <= next_prev;
					state_q    <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == sgg_pkg::CNT_W'(sgg_pkg::MUL_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == sgg_pkg::CNT_W'(sgg_pkg::DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-item payload.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			line_q <= lines.line_number;
			fs_q   <= lines.frame_start;
		end
		if (state_q == S_LOAD) begin
			hold_q       <= (start_line == end_line) || (end_line == sgg_pkg::HOLD_LINE);
			prev_color_q <= kf_a[3*sgg_pkg::CHAN_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (colors.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_line_q  <= line_q;
			out_color_q <= {blue_ch[sgg_pkg::CHAN_W-1 -: 5], green_ch[sgg_pkg::CHAN_W-1 -: 5],
				red_ch[sgg_pkg::CHAN_W-1 -: 5]};
		end
	end

	assign colors.valid        = out_valid_q;
	assign colors.line_address = out_line_q;
	assign colors.color_word   = out_color_q;

	// The current segment never passes the last keyframe.
	`SGG_ASSERT_SAME(a_seg_range, clk, arst_n, 1'b1, cur_seg_q <= LAST, "segment out of range")
	// The start keyframe never lies beyond the end keyframe.
	`SGG_ASSERT_SAME(a_seg_order, clk, arst_n, 1'b1, prev_seg_q <= cur_seg_q, "segments out of order")
	// An accepted line always starts the segment update.
	`SGG_ASSERT_NEXT(a_accept_seg, clk, arst_n, in_accept, state_q == S_SEG, "accept without update")
	// A finished color waits while the previous word is still stalled.
	`SGG_ASSERT_NEXT(a_fin_hold, clk, arst_n, (state_q == S_FIN) && out_valid_q && !colors.ready,
		(state_q == S_FIN) && out_valid_q, "result overwrote a stalled word")

endmodule

@@ rtl/sgg_ram.sv @@
module sgg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ rtl/sgg_lane.sv @@
module sgg_lane (
	input  logic                         clk,
	input  sgg_pkg::sgg_ctrl_t           ctrl,
	input  logic [sgg_pkg::CHAN_W-1:0]   chan_a,
	input  logic [sgg_pkg::CHAN_W-1:0]   chan_b,
	input  logic [sgg_pkg::LINE_W-1:0]   t0_mag,
	input  logic [sgg_pkg::LINE_W-1:0]   t1_mag,
	input  logic                         offs_neg,
	output logic [sgg_pkg::CHAN_W-1:0]   chan_out
);

	logic [sgg_pkg::CHAN_W-1:0] a_q;
	logic [sgg_pkg::CHAN_W-1:0] dmag_q;
	logic                       neg_q;
	logic [sgg_pkg::LINE_W-1:0] mplr_q;
	logic [sgg_pkg::LINE_W-1:0] dvsr_q;
	logic [sgg_pkg::LINE_W-1:0] rem_q;
	logic [sgg_pkg::PROD_W-1:0] acc_q;

	logic [sgg_pkg::CHAN_W:0]   diff;
	logic [sgg_pkg::CHAN_W:0]   diff_abs;
	logic [sgg_pkg::LINE_W:0]   rem_next;
	logic                       qbit;
	logic [sgg_pkg::PROD_W-1:0] sum;

	// Signed channel delta, split into sign and magnitude.
	assign diff     = {1'b0, chan_b} - {1'b0, chan_a};
	assign diff_abs = diff[sgg_pkg::CHAN_W] ? (~diff + 1'b1) : diff;

	// One restoring division step: bring down the next dividend bit.
	assign rem_next = {rem_q, acc_q[sgg_pkg::PROD_W-1]};
	assign qbit     = (rem_next >= {1'b0, dvsr_q});

	// Shift-add multiply, MSB of the offset first, then divide in place.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q    <= chan_a;
			dmag_q <= diff_abs[sgg_pkg::CHAN_W-1:0];
			neg_q  <= diff[sgg_pkg::CHAN_W] ^ offs_neg;
			mplr_q <= t0_mag;
			dvsr_q <= t1_mag;
			rem_q  <= '0;
			acc_q  <= '0;
		end else if (ctrl.mul) begin
			acc_q  <= {acc_q[sgg_pkg::PROD_W-2:0], 1'b0}
				+ (mplr_q[sgg_pkg::LINE_W-1] ? sgg_pkg::PROD_W'(dmag_q) : '0);
			mplr_q <= {mplr_q[sgg_pkg::LINE_W-2:0], 1'b0};
		end else if (ctrl.div) begin
			rem_q <= qbit ? sgg_pkg::LINE_W'(rem_next - {1'b0, dvsr_q})
				: rem_next[sgg_pkg::LINE_W-1:0];
			acc_q <= {acc_q[sgg_pkg::PROD_W-2:0], qbit};
		end
	end

	// Apply the truncated quotient to the start color and clamp to 0..255.
	assign sum = sgg_pkg::PROD_W'(a_q) + acc_q;
	always_comb begin
		if (neg_q) begin
			chan_out = (acc_q > sgg_pkg::PROD_W'(a_q)) ? '0 : sgg_pkg::CHAN_W'(a_q - acc_q);
		end else begin
			chan_out = (sum > sgg_pkg::PROD_W'(sgg_pkg::CHAN_MAX)) ? sgg_pkg::CHAN_MAX
				: sum[sgg_pkg::CHAN_W-1:0];
		end
	end

endmodule
